### sv/skt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared record type, status codes and controller-to-datapath command and
// status structures.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int KEY_W    = 16;
  localparam int INIT_W   = 8;
  localparam int SAL_W    = 32;
  localparam int YEARS_W  = 7;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int ENT_W    = 7;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [INIT_W-1:0]  initial_req;
    logic [SAL_W-1:0]   salary_cents;
    logic [YEARS_W-1:0] years;
  } rec_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOTFOUND  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC,
    IDX_DEC,
    IDX_CNT
  } idx_op_e;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_PREV,
    RD_NEXT
  } rd_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_INS_PREP,
    S_INS_RD,
    S_INS_WR,
    S_DEL_PREP,
    S_DEL_RD,
    S_DEL_WR,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic    load_req;
    idx_op_e idx_op;
    logic    pos_load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_new;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    code_set;
    status_e code;
    logic    res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic full;
    logic idx_lt_cnt;
    logic next_lt_cnt;
    logic idx_gt_pos;
    logic key_gt;
    logic key_eq;
    logic out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

### sv/skt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table datapath
// Record memory, request and result registers, scan index, insert position
// and record count, with the compares that steer the controller.
// ----------------------------------------------------------------------------
module skt_datapath #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire skt_pkg::dp_cmd_t              cmd_i,
  output skt_pkg::dp_sts_t                   sts_o,
  input  wire logic                          kind_i,
  input  wire logic [skt_pkg::KEY_W-1:0]     key_i,
  input  wire logic [skt_pkg::INIT_W-1:0]    initial_req_i,
  input  wire logic [skt_pkg::SAL_W-1:0]     salary_cents_i,
  input  wire logic [skt_pkg::YEARS_W-1:0]   years_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [skt_pkg::STATUS_W-1:0]       status_o,
  output logic [skt_pkg::SLOT_W-1:0]         slot_o,
  output logic [skt_pkg::ENT_W-1:0]          entries_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  skt_pkg::rec_t mem_q [CAPACITY];
  skt_pkg::rec_t rdata_q;
  skt_pkg::rec_t req_q;
  skt_pkg::rec_t wdata;
  logic          kind_q;

  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_idx;
  logic [CW:0]   idx_next;

  skt_pkg::status_e                code_q;
  logic                            out_valid_q;
  logic [skt_pkg::STATUS_W-1:0]    status_q;
  logic [skt_pkg::SLOT_W-1:0]      slot_q;
  logic [skt_pkg::ENT_W-1:0]       entries_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      kind_q             <= kind_i;
      req_q.key          <= key_i;
      req_q.initial_req  <= initial_req_i;
      req_q.salary_cents <= salary_cents_i;
      req_q.years        <= years_i;
    end
    if (cmd_i.pos_load) begin
      pos_q <= idx_q;
    end
    if (cmd_i.code_set) begin
      code_q <= cmd_i.code;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      skt_pkg::RD_PREV: rd_idx = idx_q - CW'(1);
      skt_pkg::RD_NEXT: rd_idx = idx_q + CW'(1);
      default:          rd_idx = idx_q;
    endcase
  end

  assign wdata = cmd_i.wr_new ? req_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_idx[AW-1:0]];
    end
    if (cmd_i.wr_en) begin
      mem_q[idx_q[AW-1:0]] <= wdata;
    end
  end

  always_comb begin
    case (cmd_i.idx_op)
      skt_pkg::IDX_CLR: idx_d = '0;
      skt_pkg::IDX_INC: idx_d = idx_q + CW'(1);
      skt_pkg::IDX_DEC: idx_d = idx_q - CW'(1);
      skt_pkg::IDX_CNT: idx_d = cnt_q;
      default:          idx_d = idx_q;
    endcase
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q  <= code_q;
      entries_q <= skt_pkg::ENT_W'(cnt_q);
      if (code_q inside {skt_pkg::ST_INSERTED, skt_pkg::ST_DELETED}) begin
        slot_q <= skt_pkg::SLOT_W'(pos_q);
      end else begin
        slot_q <= '0;
      end
    end
  end

  assign idx_next = {1'b0, idx_q} + (CW + 1)'(1);

  assign sts_o.kind        = kind_q;
  assign sts_o.full        = (cnt_q == CW'(CAPACITY));
  assign sts_o.idx_lt_cnt  = (idx_q < cnt_q);
  assign sts_o.next_lt_cnt = (idx_next < {1'b0, cnt_q});
  assign sts_o.idx_gt_pos  = (idx_q > pos_q);
  assign sts_o.key_gt      = (req_q.key > rdata_q.key);
  assign sts_o.key_eq      = (req_q.key == rdata_q.key);
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign entries_o   = entries_q;

endmodule
`default_nettype wire

### sv/skt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table controller
// Sequences the search, the shift of later records and the result hand-off
// for one request at a time.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire skt_pkg::dp_sts_t sts_i,
  output skt_pkg::dp_cmd_t      cmd_o
);

  skt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.idx_op   = skt_pkg::IDX_HOLD;
    cmd_o.rd_sel   = skt_pkg::RD_IDX;
    cmd_o.code     = skt_pkg::ST_INSERTED;
    case (state_q)
      skt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.idx_op   = skt_pkg::IDX_CLR;
          state_d        = skt_pkg::S_CHECK;
        end
      end
      skt_pkg::S_CHECK: begin
        if (sts_i.kind == skt_pkg::KIND_INSERT && sts_i.full) begin
          cmd_o.code_set = 1'b1;
          cmd_o.code     = skt_pkg::ST_FULL;
          state_d        = skt_pkg::S_FINISH;
        end else begin
          state_d = skt_pkg::S_SRCH_RD;
        end
      end
      skt_pkg::S_SRCH_RD: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.rd_en = 1'b1;
          state_d     = skt_pkg::S_SRCH_CMP;
        end else if (sts_i.kind == skt_pkg::KIND_INSERT) begin
          state_d = skt_pkg::S_INS_PREP;
        end else begin
          cmd_o.code_set = 1'b1;
          cmd_o.code     = skt_pkg::ST_NOTFOUND;
          state_d        = skt_pkg::S_FINISH;
        end
      end
      skt_pkg::S_SRCH_CMP: begin
        if (sts_i.kind == skt_pkg::KIND_INSERT) begin
          if (sts_i.key_gt) begin
            cmd_o.idx_op = skt_pkg::IDX_INC;
            state_d      = skt_pkg::S_SRCH_RD;
          end else if (sts_i.key_eq) begin
            cmd_o.code_set = 1'b1;
            cmd_o.code     = skt_pkg::ST_DUPLICATE;
            state_d        = skt_pkg::S_FINISH;
          end else begin
            state_d = skt_pkg::S_INS_PREP;
          end
        end else if (sts_i.key_eq) begin
          state_d = skt_pkg::S_DEL_PREP;
        end else begin
          cmd_o.idx_op = skt_pkg::IDX_INC;
          state_d      = skt_pkg::S_SRCH_RD;
        end
      end
      skt_pkg::S_INS_PREP: begin
        cmd_o.pos_load = 1'b1;
        cmd_o.idx_op   = skt_pkg::IDX_CNT;
        state_d        = skt_pkg::S_INS_RD;
      end
      skt_pkg::S_INS_RD: begin
        if (sts_i.idx_gt_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = skt_pkg::RD_PREV;
          state_d      = skt_pkg::S_INS_WR;
        end else begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_new   = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.code_set = 1'b1;
          cmd_o.code     = skt_pkg::ST_INSERTED;
          state_d        = skt_pkg::S_FINISH;
        end
      end
      skt_pkg::S_INS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.idx_op = skt_pkg::IDX_DEC;
        state_d      = skt_pkg::S_INS_RD;
      end
      skt_pkg::S_DEL_PREP: begin
        cmd_o.pos_load = 1'b1;
        state_d        = skt_pkg::S_DEL_RD;
      end
      skt_pkg::S_DEL_RD: begin
        if (sts_i.next_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = skt_pkg::RD_NEXT;
          state_d      = skt_pkg::S_DEL_WR;
        end else begin
          cmd_o.cnt_dec  = 1'b1;
          cmd_o.code_set = 1'b1;
          cmd_o.code     = skt_pkg::ST_DELETED;
          state_d        = skt_pkg::S_FINISH;
        end
      end
      skt_pkg::S_DEL_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.idx_op = skt_pkg::IDX_INC;
        state_d      = skt_pkg::S_DEL_RD;
      end
      skt_pkg::S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = skt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = skt_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/sorted_key_table_insert_delete_core.sv
`default_nettype none
// Work per request grows with S, the records compared, and M, the records moved, as
// each moved record is read and then written one slot over; a full-table insert skips
// the search and the shift. Any result also waits while an earlier result is held.
// One request is in work at a time; the core is ready again in the cycle after the
// result is loaded, while that result may still wait in the output register.
// Reset clears the record count, the controller and the result valid flag.
// ----------------------------------------------------------------------------
// Sorted key table core
// Keeps records in ascending key order; inserts at the sorted position and
// deletes by key, shifting later records, with one result per request.
// ----------------------------------------------------------------------------
module sorted_key_table_insert_delete_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic [skt_pkg::KEY_W-1:0]     key_i,
  input  wire logic [skt_pkg::INIT_W-1:0]    initial_req_i,
  input  wire logic [skt_pkg::SAL_W-1:0]     salary_cents_i,
  input  wire logic [skt_pkg::YEARS_W-1:0]   years_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [skt_pkg::STATUS_W-1:0]       status_o,
  output logic [skt_pkg::SLOT_W-1:0]         slot_o,
  output logic [skt_pkg::ENT_W-1:0]          entries_o
);

  skt_pkg::dp_cmd_t cmd;
  skt_pkg::dp_sts_t sts;

  skt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  skt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_i),
    .key_i          (key_i),
    .initial_req_i  (initial_req_i),
    .salary_cents_i (salary_cents_i),
    .years_i        (years_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .entries_o      (entries_o)
  );

endmodule
`default_nettype wire
